/* hdl/fshu_pkg.sv */
`timescale 1ns / 1ps

package fshu_pkg;

	localparam int HASH_W = 32;
	localparam int CP_W = 21;
	localparam int LEFT_W = 2;
	localparam int BYTE_W = 8;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [CP_W-1:0]   acc;
		logic [LEFT_W-1:0] left;
	} hash_state_t;

	// djb2 update: h * 33 + v, modulo 2^32
	function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] v);
		mix = (h << 5) + h + {{(HASH_W-BYTE_W){1'b0}}, v};
	endfunction

	// latin diacritic letters to their lowercase ascii base, else low byte
	function automatic logic [BYTE_W-1:0] fold_cp(input logic [CP_W-1:0] cp);
		logic [BYTE_W-1:0] res;
		res = cp[BYTE_W-1:0];
		if (cp[CP_W-1:9] == '0) begin
			case (cp[8:0]) inside
				[9'h0C0:9'h0C5], [9'h0E0:9'h0E5], [9'h100:9'h105]: res = 8'h61;
				9'h0C7, 9'h0E7, [9'h106:9'h10D]: res = 8'h63;
				[9'h10E:9'h111]: res = 8'h64;
				[9'h0C8:9'h0CB], [9'h0E8:9'h0EB], [9'h112:9'h11B]: res = 8'h65;
				[9'h11C:9'h123]: res = 8'h67;
				[9'h124:9'h127]: res = 8'h68;
				[9'h0CC:9'h0CF], [9'h0EC:9'h0EF], [9'h128:9'h131]: res = 8'h69;
				[9'h134:9'h135]: res = 8'h6A;
				[9'h136:9'h137]: res = 8'h6B;
				[9'h139:9'h142]: res = 8'h6C;
				9'h0D1, 9'h0F1, [9'h143:9'h149]: res = 8'h6E;
				[9'h0D2:9'h0D6], 9'h0D8, [9'h0F2:9'h0F6], 9'h0F8,
				[9'h14C:9'h151]: res = 8'h6F;
				[9'h154:9'h159]: res = 8'h72;
				[9'h15A:9'h161]: res = 8'h73;
				[9'h162:9'h167]: res = 8'h74;
				[9'h0D9:9'h0DC], [9'h0F9:9'h0FC], [9'h168:9'h173]: res = 8'h75;
				[9'h174:9'h175]: res = 8'h77;
				9'h0DD, 9'h0FD, 9'h0FF, [9'h176:9'h178]: res = 8'h79;
				[9'h179:9'h17E]: res = 8'h7A;
				default: res = cp[BYTE_W-1:0];
			endcase
		end
		fold_cp = res;
	endfunction

endpackage

/* hdl/fshu_step.sv */
`timescale 1ns / 1ps

module fshu_step
	import fshu_pkg::*;
(
	input  hash_state_t       cur,
	input  logic [BYTE_W-1:0] text_byte,
	input  logic              last_byte,
	input  logic              fold,
	output hash_state_t       nxt,
	output logic [HASH_W-1:0] hash_out
);

	logic              sb_mix;
	logic [BYTE_W-1:0] sb_val;
	logic [CP_W-1:0]   sb_acc;
	logic [LEFT_W-1:0] sb_left;
	logic              is_cont;
	logic [CP_W-1:0]   acc_shift;
	logic              mix_a;
	logic              mix_b;
	logic [CP_W-1:0]   cp_a;
	logic [CP_W-1:0]   acc1;
	logic [LEFT_W-1:0] left1;
	logic [BYTE_W-1:0] val_b;
	logic [HASH_W-1:0] h1;
	logic [HASH_W-1:0] h2;

	// lead / ascii / stray byte decode
	always_comb begin
		sb_mix = 1'b1;
		sb_val = text_byte;
		sb_acc = '0;
		sb_left = '0;
		case (text_byte) inside
			[8'h41:8'h5A]: sb_val = text_byte + 8'd32;
			[8'hC0:8'hDF]: begin
				sb_mix = 1'b0;
				sb_acc = {{(CP_W-5){1'b0}}, text_byte[4:0]};
				sb_left = 2'd1;
			end
			[8'hE0:8'hEF]: begin
				sb_mix = 1'b0;
				sb_acc = {{(CP_W-4){1'b0}}, text_byte[3:0]};
				sb_left = 2'd2;
			end
			[8'hF0:8'hF7]: begin
				sb_mix = 1'b0;
				sb_acc = {{(CP_W-3){1'b0}}, text_byte[2:0]};
				sb_left = 2'd3;
			end
			default: sb_val = text_byte;
		endcase
	end

	assign is_cont = (text_byte[7:6] == 2'b10);
	assign acc_shift = {cur.acc[CP_W-7:0], text_byte[5:0]};

	always_comb begin
		mix_a = 1'b0;
		mix_b = 1'b0;
		cp_a = cur.acc;
		acc1 = sb_acc;
		left1 = sb_left;
		if (cur.left != '0) begin
			if (is_cont) begin
				cp_a = acc_shift;
				acc1 = acc_shift;
				left1 = cur.left - 2'd1;
				if (left1 == '0) begin
					mix_a = 1'b1;
					acc1 = '0;
				end
			end else begin
				// truncated sequence: fold what was received, then restart
				mix_a = 1'b1;
				mix_b = sb_mix;
			end
		end else begin
			mix_b = sb_mix;
		end
		// string end with a sequence still open
		if (last_byte && left1 != '0) begin
			mix_b = 1'b1;
		end
	end

	// an open sequence at this point is only mixed at string end
	assign val_b = (left1 != '0) ? fold_cp(acc1) : sb_val;
	assign h1 = mix_a ? mix(cur.hash, fold_cp(cp_a)) : cur.hash;
	assign h2 = mix_b ? mix(h1, val_b) : h1;

	always_comb begin
		if (fold) begin
			hash_out = h2;
			nxt.hash = h2;
			nxt.acc = acc1;
			nxt.left = left1;
		end else begin
			hash_out = mix(cur.hash, text_byte);
			nxt.hash = hash_out;
			nxt.acc = '0;
			nxt.left = '0;
		end
		if (last_byte) begin
			nxt = '0;
		end
	end

endmodule

/* hdl/utf8_folding_string_hash_unit.sv */
`timescale 1ns / 1ps

// UTF-8 folding djb2 string hash. Bytes of a string arrive one per transfer on
// the slave side, tlast marking the final byte; one 32-bit hash leaves on the
// master side per string. With fold enabled, ascii capitals are lower-cased
// and latin diacritic letters U+00C0..U+017E hash as their base letter; with
// it cleared every raw byte is hashed. The unit takes one byte every cycle
// while the input side is not stalled: a byte sits in the input register
// while the fold and two chained shift-add updates settle, and a last byte
// lands its hash in the output register, which presents it on the master
// side. The input side stalls only when a last byte waits behind a result
// that the master side has not yet taken. Write fold_enable only between
// strings.
module utf8_folding_string_hash_unit
	import fshu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration: fold_enable
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	// slave side
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  logic              s_tlast,   // last_byte
	// master side
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [HASH_W-1:0] m_tdata    // [31:0] hash_value
);

	logic              fold_enable_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	hash_state_t       state_q;
	hash_state_t       state_nxt;
	logic [HASH_W-1:0] hash_nxt;
	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic              advance;
	logic              emit;

	// a non-last byte never needs the output register
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign emit = advance && last_s1;
	assign s_tready = !valid_s1 || advance;

	fshu_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.fold      (fold_enable_q),
		.nxt       (state_nxt),
		.hash_out  (hash_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_enable_q <= 1'b1;
		end else if (cfg_we) begin
			fold_enable_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// running hash and pending utf-8 sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_hash_q <= hash_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_hash_q;

	// a processed last byte always leaves a result and a fresh string state
	a_emit_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid && m_tdata == $past(hash_nxt))
		else $error("hash of last byte not presented");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> state_q.hash == '0 && state_q.left == '0 && state_q.acc == '0)
		else $error("string state not cleared after last byte");

	// input stalls only behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a pending result");

	// no result appears without a last byte behind it
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(emit))
		else $error("result without a last byte");

endmodule
